>>> hdl/mtte_pkg.sv
// Shared types and constants for the marker triggered text extractor.
// No dependencies; imported by the top level.
package mtte_pkg;

    // Default values of the top-level parameters
    localparam int PATTERN_MAX_DEF  = 48;
    localparam int MAX_RECORDS_DEF  = 1024;
    localparam int RECORD_CHARS_DEF = 128;

    // Marker storage: six 64-bit registers, eight bytes each
    localparam int PATTERN_REGS  = 6;
    localparam int PATTERN_STORE = 48;

    // Configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    // Result field widths
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 10;
    localparam int POS_W   = 7;
    localparam int LEN_W   = 6;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_PAT_A   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_B   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT_C   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAT_D   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PAT_E   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PAT_F   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PAT_LEN = 3'd6;

    // Record delimiters
    localparam logic [BYTE_W-1:0] OPEN_MARK  = 8'h3C;
    localparam logic [BYTE_W-1:0] CLOSE_MARK = 8'h3E;

    // One result
    typedef struct packed {
        logic [BYTE_W-1:0]  text_byte;
        logic [INDEX_W-1:0] record_index;
        logic [POS_W-1:0]   char_position;
        logic               end_of_record;
        logic               record_truncated;
    } t_result;

endpackage

>>> hdl/marker_triggered_text_extractor.sv
// Throughput: one byte per cycle while o_in_ready is high.
// The marker compare over the whole window is parallel, and each result is registered.
// An output register plus one skid entry let a byte be accepted while a result waits.
// Reset (i_rst_n low, synchronous): searching, empty window, no records closed,
// marker registers zero and marker length one. Window bytes themselves are not cleared.
// Depends on mtte_pkg.
module marker_triggered_text_extractor #(
    parameter int PATTERN_MAX  = mtte_pkg::PATTERN_MAX_DEF,
    parameter int MAX_RECORDS  = mtte_pkg::MAX_RECORDS_DEF,
    parameter int RECORD_CHARS = mtte_pkg::RECORD_CHARS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtte_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mtte_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mtte_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // Input bytes
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mtte_pkg::BYTE_W-1:0]     i_data_byte,
    // Results
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mtte_pkg::BYTE_W-1:0]     o_text_byte,
    output logic [mtte_pkg::INDEX_W-1:0]    o_record_index,
    output logic [mtte_pkg::POS_W-1:0]      o_char_position,
    output logic                            o_end_of_record,
    output logic                            o_record_truncated
);
    import mtte_pkg::*;

    localparam int WIN_W   = PATTERN_MAX * BYTE_W;
    localparam int WF_W    = $clog2(PATTERN_MAX + 1);
    localparam int RC_W    = $clog2(MAX_RECORDS + 1);
    localparam int RL_W    = $clog2(RECORD_CHARS + 1);
    localparam int LEN_CAP = (PATTERN_MAX < PATTERN_STORE) ? PATTERN_MAX : PATTERN_STORE;
    localparam int MRK_W   = PATTERN_STORE * BYTE_W;

    // Configuration registers
    logic [APB_DATA_W-1:0] r_pat [PATTERN_REGS];
    logic [LEN_W-1:0]      r_plen;

    // Extraction state
    logic [WIN_W-1:0] r_win;
    logic [WF_W-1:0]  r_fill;
    logic             r_copying;
    logic [RC_W-1:0]  r_rec_closed;
    logic [RL_W-1:0]  r_rec_len;
    logic             r_ovf;

    // Output register and skid entry
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic [WIN_W-1:0] n_win;
    logic [WF_W-1:0]  n_fill;
    logic             n_copying;
    logic [RC_W-1:0]  n_rec_closed;
    logic [RL_W-1:0]  n_rec_len;
    logic             n_ovf;
    t_result          n_out, n_skid;
    logic             n_out_valid, n_skid_valid;

    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_cfg_idx;
    logic                 w_in_fire;
    logic                 w_out_fire;
    logic                 w_done;
    logic [MRK_W-1:0]     w_marker;
    logic [LEN_W-1:0]     w_eff;
    logic [WIN_W-1:0]     w_shift_win;
    logic [WF_W-1:0]      w_shift_fill;
    logic [WIN_W-1:0]     w_rev;
    logic [WIN_W-1:0]     w_aligned;
    logic [WF_W-1:0]      w_shamt;
    logic                 w_mismatch;
    logic                 w_match;
    logic                 w_res_valid;
    t_result              w_res;

    // Configuration access
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PATTERN_REGS; i++) begin
                r_pat[i] <= '0;
            end
            r_plen <= LEN_W'(1);
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_PAT_A:   r_pat[0] <= pwdata;
                REG_PAT_B:   r_pat[1] <= pwdata;
                REG_PAT_C:   r_pat[2] <= pwdata;
                REG_PAT_D:   r_pat[3] <= pwdata;
                REG_PAT_E:   r_pat[4] <= pwdata;
                REG_PAT_F:   r_pat[5] <= pwdata;
                REG_PAT_LEN: r_plen   <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_cfg_idx)
            REG_PAT_A:   prdata = r_pat[0];
            REG_PAT_B:   prdata = r_pat[1];
            REG_PAT_C:   prdata = r_pat[2];
            REG_PAT_D:   prdata = r_pat[3];
            REG_PAT_E:   prdata = r_pat[4];
            REG_PAT_F:   prdata = r_pat[5];
            REG_PAT_LEN: prdata = APB_DATA_W'(r_plen);
            default:     prdata = '0;
        endcase
    end

    // Flatten the marker, byte 0 lowest
    assign w_marker = {r_pat[5], r_pat[4], r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    // Clamp the marker length to one..LEN_CAP
    always_comb begin
        if (r_plen == '0) begin
            w_eff = LEN_W'(1);
        end else if ({1'b0, r_plen} > 7'(LEN_CAP)) begin
            w_eff = LEN_W'(LEN_CAP);
        end else begin
            w_eff = r_plen;
        end
    end

    // Shift the new byte into the window, newest byte lowest
    assign w_shift_win  = WIN_W'({r_win, i_data_byte});
    assign w_shift_fill = (r_fill < WF_W'(PATTERN_MAX)) ? r_fill + 1'b1 : r_fill;

    // Reverse the window byte order so the oldest byte sits lowest
    always_comb begin
        for (int m = 0; m < PATTERN_MAX; m++) begin
            w_rev[m*BYTE_W +: BYTE_W] = w_shift_win[(PATTERN_MAX-1-m)*BYTE_W +: BYTE_W];
        end
    end

    // Align the last w_eff bytes with marker byte 0
    assign w_shamt   = WF_W'(PATTERN_MAX) - WF_W'(w_eff);
    assign w_aligned = w_rev >> {w_shamt, 3'b000};

    // Compare each marker byte in use
    always_comb begin
        w_mismatch = 1'b0;
        for (int k = 0; k < LEN_CAP; k++) begin
            if (LEN_W'(k) < w_eff
                && w_aligned[k*BYTE_W +: BYTE_W] != w_marker[k*BYTE_W +: BYTE_W]) begin
                w_mismatch = 1'b1;
            end
        end
    end

    assign w_match = !w_mismatch && (7'(w_shift_fill) >= 7'(w_eff));

    // Handshakes
    assign o_in_ready = !r_skid_valid;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = r_out_valid && i_out_ready;
    assign w_done     = r_rec_closed >= RC_W'(MAX_RECORDS);

    // Advance the extraction state for one accepted byte
    always_comb begin
        n_win        = r_win;
        n_fill       = r_fill;
        n_copying    = r_copying;
        n_rec_closed = r_rec_closed;
        n_rec_len    = r_rec_len;
        n_ovf        = r_ovf;
        w_res_valid  = 1'b0;
        w_res        = '{text_byte:     i_data_byte,
                         record_index:  INDEX_W'(r_rec_closed),
                         char_position: POS_W'(r_rec_len),
                         end_of_record: 1'b0,
                         record_truncated: 1'b0};
        if (w_in_fire && !w_done) begin
            if (!r_copying) begin
                n_win     = w_shift_win;
                n_fill    = w_shift_fill;
                n_copying = w_match;
            end else if (i_data_byte == OPEN_MARK) begin
                w_res_valid            = 1'b1;
                w_res.text_byte        = '0;
                w_res.char_position    = '0;
                w_res.end_of_record    = 1'b1;
                w_res.record_truncated = r_ovf;
                n_rec_closed           = r_rec_closed + 1'b1;
                n_rec_len              = '0;
                n_ovf                  = 1'b0;
                n_copying              = 1'b0;
                n_fill                 = '0;
            end else if (i_data_byte == CLOSE_MARK) begin
                // drop the closing bracket
            end else if (r_rec_len >= RL_W'(RECORD_CHARS)) begin
                n_ovf = 1'b1;
            end else begin
                w_res_valid = 1'b1;
                n_rec_len   = r_rec_len + 1'b1;
            end
        end
    end

    // Output register with one skid entry
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (w_res_valid) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_res_valid) begin
            n_skid       = w_res;
            n_skid_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_copying    <= 1'b0;
            r_rec_closed <= '0;
            r_rec_len    <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_fill       <= n_fill;
            r_copying    <= n_copying;
            r_rec_closed <= n_rec_closed;
            r_rec_len    <= n_rec_len;
            r_ovf        <= n_ovf;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload: window bytes and results
    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid        = r_out_valid;
    assign o_text_byte        = r_out.text_byte;
    assign o_record_index     = r_out.record_index;
    assign o_char_position    = r_out.char_position;
    assign o_end_of_record    = r_out.end_of_record;
    assign o_record_truncated = r_out.record_truncated;

    // A skid entry only exists behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output valid");

    // Copy mode is only entered from a non-empty window
    a_copy_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_copying |-> (r_fill != '0))
        else $error("copying with empty window");

    // Overflow only at a full record in copy mode
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_copying && r_rec_len == RL_W'(RECORD_CHARS)))
        else $error("overflow flag without full record");

    // Counters stay in range
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_closed <= RC_W'(MAX_RECORDS)) && (r_rec_len <= RL_W'(RECORD_CHARS)))
        else $error("record counters out of range");

    // A result stalled at the output moves only when taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("held result changed");

endmodule
